[hw/rtl/tci_pkg.sv]
// shared constants for the triangle colour interpolation pipeline
package tci_pkg;
  localparam int NUM_STAGES = 15;
  localparam int REG_BITS = 24;
  localparam int INDEX_BITS = 3;
  localparam logic [INDEX_BITS-1:0] REG_V0_POS = 3'd0;
  localparam logic [INDEX_BITS-1:0] REG_V0_COL = 3'd1;
  localparam logic [INDEX_BITS-1:0] REG_V1_POS = 3'd2;
  localparam logic [INDEX_BITS-1:0] REG_V1_COL = 3'd3;
  localparam logic [INDEX_BITS-1:0] REG_V2_POS = 3'd4;
  localparam logic [INDEX_BITS-1:0] REG_V2_COL = 3'd5;
  localparam int ST_DELTA = 0;
  localparam int ST_PROD = 1;
  localparam int ST_CROSS = 2;
  localparam int ST_MUL = 3;
  localparam int ST_SUM = 4;
  localparam int ST_NORM = 5;
  localparam int ST_RANGE = 6;
  localparam int ST_DIV = 7;
  localparam int QUOT_BITS = 8;
endpackage

[hw/rtl/tci_geom.sv]
// geometry stages: edge deltas, pixel offsets and the xy cross product
module tci_geom import tci_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic [NUM_STAGES-1:0]        en,
  input  logic [REG_BITS-1:0]          pos0,
  input  logic [REG_BITS-1:0]          pos1,
  input  logic [REG_BITS-1:0]          pos2,
  input  logic [COORD_BITS-1:0]        pixel_x,
  input  logic [COORD_BITS-1:0]        pixel_y,
  output logic signed [COORD_BITS:0]   dx1,
  output logic signed [COORD_BITS:0]   dy1,
  output logic signed [COORD_BITS:0]   dx2,
  output logic signed [COORD_BITS:0]   dy2,
  output logic signed [COORD_BITS:0]   ex,
  output logic signed [COORD_BITS:0]   ey,
  output logic signed [2*COORD_BITS+2:0] nz,
  output logic                         flat
);
  localparam int C = COORD_BITS;
  localparam int PW = 2*C+2;

  function automatic logic signed [C:0] xof(input logic [REG_BITS-1:0] p);
    return $signed({1'b0, p[C-1:0]});
  endfunction

  function automatic logic signed [C:0] yof(input logic [REG_BITS-1:0] p);
    logic [2*REG_BITS-1:0] w;
    w = {{REG_BITS{1'b0}}, p} >> C;
    return $signed({1'b0, w[C-1:0]});
  endfunction

  logic signed [C:0] ex0, ey0, ex1, ey1;
  logic signed [PW-1:0] p1, p2;

  always_ff @(posedge clk) begin
    if (en[ST_DELTA]) begin
      dx1 <= xof(pos1) - xof(pos0);
      dy1 <= yof(pos1) - yof(pos0);
      dx2 <= xof(pos2) - xof(pos0);
      dy2 <= yof(pos2) - yof(pos0);
      ex0 <= $signed({1'b0, pixel_x}) - xof(pos0);
      ey0 <= $signed({1'b0, pixel_y}) - yof(pos0);
    end
    if (en[ST_PROD]) begin
      p1 <= PW'(dx1 * dy2);
      p2 <= PW'(dy1 * dx2);
      ex1 <= ex0;
      ey1 <= ey0;
    end
    if (en[ST_CROSS]) begin
      nz <= (PW+1)'(p1) - (PW+1)'(p2);
      flat <= (p1 == p2);
      ex <= ex1;
      ey <= ey1;
    end
  end
endmodule

[hw/rtl/tci_chan.sv]
// one colour channel: plane numerator and pipelined restoring division
module tci_chan import tci_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                           clk,
  input  logic [NUM_STAGES-1:0]          en,
  input  logic [7:0]                     col0,
  input  logic [7:0]                     col1,
  input  logic [7:0]                     col2,
  input  logic signed [COORD_BITS:0]     dx1,
  input  logic signed [COORD_BITS:0]     dy1,
  input  logic signed [COORD_BITS:0]     dx2,
  input  logic signed [COORD_BITS:0]     dy2,
  input  logic signed [COORD_BITS:0]     ex,
  input  logic signed [COORD_BITS:0]     ey,
  input  logic signed [2*COORD_BITS+2:0] nz,
  output logic [7:0]                     level
);
  localparam int C = COORD_BITS;
  localparam int MW = C+10;
  localparam int NW = C+11;
  localparam int AW = 2*C+12;
  localparam int SW = 2*C+14;
  localparam int RW = 2*C+15;
  localparam int DW = 2*C+3;

  logic signed [8:0] c0_0, dc1, dc2, c0_1, c0_2;
  logic signed [MW-1:0] m1, m2, m3, m4;
  logic signed [NW-1:0] nx, ny;
  logic signed [AW-1:0] pa, pb, cz;
  logic signed [DW-1:0] nz3, nz4;
  logic signed [SW-1:0] num;
  logic signed [RW-1:0] n5;
  logic [DW-1:0] d5;

  logic signed [RW-1:0] r [0:QUOT_BITS];
  logic [DW-1:0] d [0:QUOT_BITS];
  logic [QUOT_BITS-1:0] q [0:QUOT_BITS];
  logic under [0:QUOT_BITS];
  logic over [0:QUOT_BITS];

  always_ff @(posedge clk) begin
    if (en[ST_DELTA]) begin
      c0_0 <= $signed({1'b0, col0});
      dc1 <= $signed({1'b0, col1}) - $signed({1'b0, col0});
      dc2 <= $signed({1'b0, col2}) - $signed({1'b0, col0});
    end
    if (en[ST_PROD]) begin
      m1 <= MW'(dy1 * dc2);
      m2 <= MW'(dc1 * dy2);
      m3 <= MW'(dc1 * dx2);
      m4 <= MW'(dx1 * dc2);
      c0_1 <= c0_0;
    end
    if (en[ST_CROSS]) begin
      nx <= NW'(m1) - NW'(m2);
      ny <= NW'(m3) - NW'(m4);
      c0_2 <= c0_1;
    end
    if (en[ST_MUL]) begin
      pa <= AW'(nx * ex);
      pb <= AW'(ny * ey);
      cz <= AW'(c0_2 * nz);
      nz3 <= nz;
    end
    if (en[ST_SUM]) begin
      num <= SW'(cz) - SW'(pa) - SW'(pb);
      nz4 <= nz3;
    end
    if (en[ST_NORM]) begin
      // make the divisor positive
      if (nz4 < 0) begin
        n5 <= -RW'(num);
        d5 <= DW'(-nz4);
      end else begin
        n5 <= RW'(num);
        d5 <= DW'(nz4);
      end
    end
    if (en[ST_RANGE]) begin
      r[0] <= n5;
      d[0] <= d5;
      q[0] <= '0;
      under[0] <= (n5 < 0);
      over[0] <= (n5 >= $signed(RW'(d5) << QUOT_BITS));
    end
  end

  for (genvar j = 0; j < QUOT_BITS; j++) begin : g_step
    localparam int B = QUOT_BITS-1-j;
    logic signed [RW-1:0] trial;
    assign trial = r[j] - $signed(RW'(d[j]) << B);
    always_ff @(posedge clk) begin
      if (en[ST_DIV+j]) begin
        d[j+1] <= d[j];
        under[j+1] <= under[j];
        over[j+1] <= over[j];
        if (trial >= 0) begin
          r[j+1] <= trial;
          q[j+1] <= q[j] | (QUOT_BITS'(1) << B);
        end else begin
          r[j+1] <= r[j];
          q[j+1] <= q[j];
        end
      end
    end
  end

  assign level = under[QUOT_BITS] ? 8'd0 : (over[QUOT_BITS] ? 8'd255 : q[QUOT_BITS]);
endmodule

[hw/rtl/triangle_color_interpolation.sv]
// top level: registers, pipeline control and the three colour channels
// One pixel request can enter every cycle while in_stall is low. Its colour is on the
// output at the last stage, and is taken there when out_stall is low. The pipeline
// holds up to 15 requests, and a stall on the output only holds back requests once every
// stage ahead of the input is occupied. Each channel runs an exact plane evaluation
// followed by an eight step restoring divider, one quotient bit per stage. Collinear
// vertices give black with degenerate set.
module triangle_color_interpolation import tci_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [INDEX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue,
  output logic                  degenerate
);
  localparam int C = COORD_BITS;

  logic [REG_BITS-1:0] pos0, pos1, pos2, col0, col1, col2;
  logic [NUM_STAGES-1:0] vld, adv;
  logic [NUM_STAGES-1:ST_CROSS+1] flat_pipe;
  logic signed [C:0] dx1, dy1, dx2, dy2, ex, ey;
  logic signed [2*C+2:0] nz;
  logic flat;
  logic [7:0] lr, lg, lb;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos0 <= '0; pos1 <= '0; pos2 <= '0;
      col0 <= '0; col1 <= '0; col2 <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_V0_POS: pos0 <= cfg_data;
        REG_V0_COL: col0 <= cfg_data;
        REG_V1_POS: pos1 <= cfg_data;
        REG_V1_COL: col1 <= cfg_data;
        REG_V2_POS: pos2 <= cfg_data;
        REG_V2_COL: col2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage may load when it is empty or its occupant moves on
  always_comb begin
    adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !out_stall;
    for (int i = NUM_STAGES-2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_CROSS+1]) flat_pipe[ST_CROSS+1] <= flat;
    for (int i = ST_CROSS+2; i < NUM_STAGES; i++) begin
      if (adv[i]) flat_pipe[i] <= flat_pipe[i-1];
    end
  end

  tci_geom #(.COORD_BITS(C)) u_geom (
    .clk(clk), .en(adv), .pos0(pos0), .pos1(pos1), .pos2(pos2),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .dx1(dx1), .dy1(dy1), .dx2(dx2), .dy2(dy2), .ex(ex), .ey(ey),
    .nz(nz), .flat(flat)
  );

  tci_chan #(.COORD_BITS(C)) u_red (
    .clk(clk), .en(adv), .col0(col0[23:16]), .col1(col1[23:16]), .col2(col2[23:16]),
    .dx1(dx1), .dy1(dy1), .dx2(dx2), .dy2(dy2), .ex(ex), .ey(ey), .nz(nz), .level(lr)
  );

  tci_chan #(.COORD_BITS(C)) u_green (
    .clk(clk), .en(adv), .col0(col0[15:8]), .col1(col1[15:8]), .col2(col2[15:8]),
    .dx1(dx1), .dy1(dy1), .dx2(dx2), .dy2(dy2), .ex(ex), .ey(ey), .nz(nz), .level(lg)
  );

  tci_chan #(.COORD_BITS(C)) u_blue (
    .clk(clk), .en(adv), .col0(col0[7:0]), .col1(col1[7:0]), .col2(col2[7:0]),
    .dx1(dx1), .dy1(dy1), .dx2(dx2), .dy2(dy2), .ex(ex), .ey(ey), .nz(nz), .level(lb)
  );

  assign out_valid = vld[NUM_STAGES-1];
  assign degenerate = flat_pipe[NUM_STAGES-1];
  assign red = degenerate ? 8'd0 : lr;
  assign green = degenerate ? 8'd0 : lg;
  assign blue = degenerate ? 8'd0 : lb;

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (vld == {NUM_STAGES{1'b1}}))
    else $error("input held back while a stage is free");

  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input held back with output free");

  a_flat_black: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
    else $error("collinear triangle gave colour");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present straight after reset");
endmodule

[verif/tb.sv]
// self-checking testbench for the triangle colour interpolation block
module tb import tci_pkg::*; ();

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       degen;
  } colour_t;

  class colour_scoreboard;
    logic [23:0] pos[3];
    logic [23:0] col[3];
    colour_t     pending[$];
    int          errors;
    int          checked;

    function new();
      for (int i = 0; i < 3; i++) begin
        pos[i] = '0;
        col[i] = '0;
      end
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [INDEX_BITS-1:0] idx, logic [23:0] value);
      if (idx <= REG_V2_COL) begin
        if (idx[0] == 1'b0) pos[idx >> 1] = value;
        else col[idx >> 1] = value;
      end
    endfunction

    function logic [7:0] plane_channel(longint px, longint py, int shift, longint nz);
      longint x0, y0, dx1, dy1, dx2, dy2, c0, dc1, dc2, nx, ny, num, z;
      x0 = pos[0][11:0];
      y0 = pos[0][23:12];
      dx1 = longint'(pos[1][11:0]) - x0;
      dy1 = longint'(pos[1][23:12]) - y0;
      dx2 = longint'(pos[2][11:0]) - x0;
      dy2 = longint'(pos[2][23:12]) - y0;
      c0 = (col[0] >> shift) & 8'hff;
      dc1 = longint'((col[1] >> shift) & 8'hff) - c0;
      dc2 = longint'((col[2] >> shift) & 8'hff) - c0;
      nx = dy1 * dc2 - dc1 * dy2;
      ny = dc1 * dx2 - dx1 * dc2;
      num = nx * (px - x0) + ny * (py - y0);
      z = (c0 * nz - num) / nz;
      if (z < 0) z = 0;
      if (z > 255) z = 255;
      return z[7:0];
    endfunction

    function void note_pixel(logic [11:0] x, logic [11:0] y);
      longint nz;
      colour_t c;
      nz = (longint'(pos[1][11:0]) - pos[0][11:0]) * (longint'(pos[2][23:12]) - pos[0][23:12])
         - (longint'(pos[1][23:12]) - pos[0][23:12]) * (longint'(pos[2][11:0]) - pos[0][11:0]);
      if (nz == 0) begin
        c = '{8'd0, 8'd0, 8'd0, 1'b1};
      end else begin
        c.r = plane_channel(x, y, 16, nz);
        c.g = plane_channel(x, y, 8, nz);
        c.b = plane_channel(x, y, 0, nz);
        c.degen = 1'b0;
      end
      pending = {pending, c};
    endfunction

    function void check_colour(colour_t got);
      colour_t exp_c;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_c = pending.pop_front();
      if (got.r !== exp_c.r) begin
        $display("%0t: red expected %0d actual %0d", $time, exp_c.r, got.r);
        errors++;
      end
      if (got.g !== exp_c.g) begin
        $display("%0t: green expected %0d actual %0d", $time, exp_c.g, got.g);
        errors++;
      end
      if (got.b !== exp_c.b) begin
        $display("%0t: blue expected %0d actual %0d", $time, exp_c.b, got.b);
        errors++;
      end
      if (got.degen !== exp_c.degen) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, exp_c.degen, got.degen);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [INDEX_BITS-1:0] cfg_index = '0;
  logic [REG_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [11:0] pixel_x = '0;
  logic [11:0] pixel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] red, green, blue;
  logic degenerate;

  colour_scoreboard sb = new();
  bit idle_on = 1'b1;
  int sent = 0;
  int triangles = 0;

  triangle_color_interpolation i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .pixel_x(pixel_x), .pixel_y(pixel_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .red(red), .green(green), .blue(blue), .degenerate(degenerate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_colour('{red, green, blue, degenerate});
  end

  // output stall in random bursts
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(logic [INDEX_BITS-1:0] idx, logic [23:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic set_triangle(logic [23:0] p0, logic [23:0] c0, logic [23:0] p1,
                              logic [23:0] c1, logic [23:0] p2, logic [23:0] c2);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 4) @(posedge clk);
    write_reg(REG_V0_POS, p0);
    write_reg(REG_V0_COL, c0);
    write_reg(REG_V1_POS, p1);
    write_reg(REG_V1_COL, c1);
    write_reg(REG_V2_POS, p2);
    write_reg(REG_V2_COL, c2);
    write_reg(3'd6 + 3'($urandom_range(0, 1)), 24'($urandom()));
    cfg_write <= 1'b0;
    triangles++;
  endtask

  // one pixel request, with an optional random gap first
  task automatic send_pixel(logic [11:0] x, logic [11:0] y);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_x <= x;
    pixel_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(x, y);
    sent++;
  endtask

  function automatic logic [23:0] rand_pos(int spread);
    logic [11:0] x, y;
    x = (spread == 0) ? 12'($urandom()) : 12'($urandom_range(0, spread));
    y = (spread == 0) ? 12'($urandom()) : 12'($urandom_range(0, spread));
    return {y, x};
  endfunction

  task automatic pixel_burst(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) send_pixel(12'($urandom()), 12'($urandom()));
      else send_pixel(12'($urandom_range(0, 300)), 12'($urandom_range(0, 300)));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int sp;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset state: all vertices at origin, collinear
    send_pixel(12'd5, 12'd7);
    in_valid <= 1'b0;
    // right triangle with pure channels
    set_triangle({12'd0, 12'd0}, 24'hff0000, {12'd0, 12'd100}, 24'h00ff00,
                 {12'd100, 12'd0}, 24'h0000ff);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd100, 12'd0);
    send_pixel(12'd0, 12'd100);
    send_pixel(12'd33, 12'd33);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(12'd50, 12'hfff);
    in_valid <= 1'b0;
    // extreme corners, negative orientation, full colour swing
    set_triangle({12'hfff, 12'hfff}, 24'hffffff, {12'd0, 12'hfff}, 24'h000000,
                 {12'hfff, 12'd0}, 24'h80ff01);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hfff, 12'hfff);
    send_pixel(12'h800, 12'h7ff);
    send_pixel(12'h555, 12'haaa);
    in_valid <= 1'b0;
    // collinear vertices
    set_triangle({12'd1, 12'd1}, 24'h123456, {12'd2, 12'd2}, 24'hffffff,
                 {12'd9, 12'd9}, 24'habcdef);
    send_pixel(12'd3, 12'd4);
    send_pixel(12'hfff, 12'd0);
    in_valid <= 1'b0;
    // random triangles, mostly small and near the pixels
    while (sent < 1000) begin
      sp = $urandom_range(0, 3);
      set_triangle(rand_pos(sp == 0 ? 0 : 300), 24'($urandom()),
                   rand_pos(sp == 0 ? 0 : 300), 24'($urandom()),
                   (sp == 3) ? {12'd150, 12'd150} : rand_pos(sp == 0 ? 0 : 300),
                   24'($urandom()));
      if (sent > 900) idle_on = 1'b0;
      pixel_burst($urandom_range(10, 40));
    end
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 5) @(posedge clk);
    $display("%0d pixels over %0d triangle settings, %0d results checked",
             sent, triangles, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** triangle_color_interpolation: PASSED **");
    end else begin
      $display("** triangle_color_interpolation: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("** triangle_color_interpolation: FAILED **");
    $finish;
  end
endmodule
